@@ src/ssfs_pkg.sv @@
// Shared types and constants of the sprite sheet frame sequencer.
package ssfs_pkg;

    localparam int CD_W       = 26;
    localparam int ELAPSED_W  = 16;
    localparam int CELL_W     = 20;
    localparam int COLS_W     = 8;
    localparam int FRAME_W    = 10;
    localparam int PERIOD_W   = 24;
    localparam int PAD_W      = 8;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 12;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_WIDTH  = 3'd0,
        REG_CELL_HEIGHT = 3'd1,
        REG_NUM_COLUMNS = 3'd2,
        REG_FIRST_FRAME = 3'd3,
        REG_LAST_FRAME  = 3'd4,
        REG_LOOP_ENABLE = 3'd5,
        REG_FRAME_PER   = 3'd6,
        REG_PADDING     = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [CELL_W-1:0]     cell_width_q8;
        logic [CELL_W-1:0]     cell_height_q8;
        logic [COLS_W-1:0]     num_columns;
        logic [FRAME_W-1:0]    first_frame;
        logic [FRAME_W-1:0]    last_frame;
        logic                  loop_enable;
        logic [PERIOD_W-1:0]   frame_period;
        logic [4*PAD_W-1:0]    padding_packed;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic div_start;
        logic div_step;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_e;

endpackage

@@ src/sprite_sheet_frame_sequencer.sv @@
// Top level of the sprite sheet frame sequencer: config registers, controller, datapath.
//
//   Port group        Dir   Beat contents
//   s_t*              in    tuser: op; tdata: elapsed
//   m_t*              out   tdata: src_x, src_y, src_w, src_h, frame_now
//   cfg_*             in    cfg_index selects register, cfg_data holds value
//
// An input beat passes through accept, divider load, FRAME_BITS
// restoring divide steps for column and row, multiply, output load.
// Reset (aresetn low, synchronous) sets frame 1, countdown 0, registers to defaults.
// A stalled result sits in the output register; the next beat is accepted
// meanwhile and its result waits in the last step until the register frees.
module sprite_sheet_frame_sequencer #(
    parameter int FRAME_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssfs_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] elapsed
    input  logic                                s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] src_x, [31:16] src_y, [43:32] src_w, [55:44] src_h,
    // [65:56] frame_now, [71:66] zero
    output logic [ssfs_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ssfs_pkg::cfg_t cfg_reg, cfg_next;
    ssfs_pkg::cmd_t cmd;
    ssfs_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (ssfs_pkg::cfg_reg_e'(cfg_index))
                ssfs_pkg::REG_CELL_WIDTH:  cfg_next.cell_width_q8  = cfg_data[19:0];
                ssfs_pkg::REG_CELL_HEIGHT: cfg_next.cell_height_q8 = cfg_data[19:0];
                ssfs_pkg::REG_NUM_COLUMNS: cfg_next.num_columns    = cfg_data[7:0];
                ssfs_pkg::REG_FIRST_FRAME: cfg_next.first_frame    = cfg_data[9:0];
                ssfs_pkg::REG_LAST_FRAME:  cfg_next.last_frame     = cfg_data[9:0];
                ssfs_pkg::REG_LOOP_ENABLE: cfg_next.loop_enable    = cfg_data[0];
                ssfs_pkg::REG_FRAME_PER:   cfg_next.frame_period   = cfg_data[23:0];
                ssfs_pkg::REG_PADDING:     cfg_next.padding_packed = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_width_q8  <= ssfs_pkg::CELL_W'(256);
            cfg_reg.cell_height_q8 <= ssfs_pkg::CELL_W'(256);
            cfg_reg.num_columns    <= ssfs_pkg::COLS_W'(1);
            cfg_reg.first_frame    <= ssfs_pkg::FRAME_W'(1);
            cfg_reg.last_frame     <= ssfs_pkg::FRAME_W'(1);
            cfg_reg.loop_enable    <= 1'b1;
            cfg_reg.frame_period   <= ssfs_pkg::PERIOD_W'(1);
            cfg_reg.padding_packed <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ssfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssfs_dpath #(
        .FRAME_BITS (FRAME_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg_reg),
        .s_op      (s_tuser),
        .s_elapsed (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // One beat in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat still in work");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // A result appears only from an output load
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without output load");

endmodule

@@ src/ssfs_ctrl.sv @@
// Sequencing state machine of the sprite sheet frame sequencer.
module ssfs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ssfs_pkg::sts_t sts,
    output ssfs_pkg::cmd_t cmd
);

    ssfs_pkg::state_e state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ssfs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = ssfs_pkg::ST_PREP;
            end
            ssfs_pkg::ST_PREP: state_next = ssfs_pkg::ST_DIV;
            ssfs_pkg::ST_DIV: begin
                if (sts.div_last) state_next = ssfs_pkg::ST_MUL;
            end
            ssfs_pkg::ST_MUL: state_next = ssfs_pkg::ST_OUT;
            ssfs_pkg::ST_OUT: begin
                if (sts.out_free) state_next = ssfs_pkg::ST_IDLE;
            end
            default: state_next = ssfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ssfs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
            end
            ssfs_pkg::ST_PREP: cmd.div_start = 1'b1;
            ssfs_pkg::ST_DIV:  cmd.div_step  = 1'b1;
            ssfs_pkg::ST_MUL:  cmd.mul       = 1'b1;
            ssfs_pkg::ST_OUT:  cmd.load_out  = sts.out_free;
            default: begin
                s_tready = 1'b0;
                cmd      = '0;
            end
        endcase
    end

endmodule

@@ src/ssfs_dpath.sv @@
// Datapath: countdown, frame index, column divider, rectangle math, output register.
module ssfs_dpath #(
    parameter int FRAME_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ssfs_pkg::cmd_t                     cmd,
    output ssfs_pkg::sts_t                     sts,
    input  ssfs_pkg::cfg_t                     cfg,
    input  logic                               s_op,
    input  logic [ssfs_pkg::ELAPSED_W-1:0]     s_elapsed,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ssfs_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam int CMP_W = (FRAME_BITS + 1 > ssfs_pkg::FRAME_W) ?
                           FRAME_BITS + 1 : ssfs_pkg::FRAME_W;
    localparam int PX_W  = ssfs_pkg::CELL_W + ssfs_pkg::COLS_W;
    localparam int PY_W  = ssfs_pkg::CELL_W + FRAME_BITS;
    localparam int XP_W  = PX_W + 1 - ssfs_pkg::FRAC_W;
    localparam int YP_W  = PY_W + 1 - ssfs_pkg::FRAC_W;
    localparam int SUB_W = ssfs_pkg::PAD_W + 1 + ssfs_pkg::FRAC_W;

    logic [ssfs_pkg::CD_W-1:0]   countdown_reg, countdown_next;
    logic [FRAME_BITS-1:0]       frame_reg, frame_next;
    logic [FRAME_BITS-1:0]       quot_reg, quot_next;
    logic [ssfs_pkg::COLS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [PX_W-1:0]             prod_x_reg, prod_x_next;
    logic [PY_W-1:0]             prod_y_reg, prod_y_next;
    logic [ssfs_pkg::M_TDATA_W-1:0] tdata_reg, tdata_next;
    logic                        tvalid_reg, tvalid_next;

    logic [ssfs_pkg::CD_W-1:0]   cd_dec;
    logic [FRAME_BITS:0]         frame_inc;
    logic [FRAME_BITS-1:0]       frame_adv;
    logic [FRAME_BITS-1:0]       frame_idx;
    logic [ssfs_pkg::COLS_W-1:0] cols;
    logic [ssfs_pkg::COLS_W:0]   trial, diff;
    logic                        ge;
    logic [ssfs_pkg::PAD_W-1:0]  pad_l, pad_r, pad_t, pad_b;
    logic [PX_W:0]               sum_x;
    logic [PY_W:0]               sum_y;
    logic [XP_W-1:0]             pix_x;
    logic [YP_W-1:0]             pix_y;
    logic [ssfs_pkg::POS_W-1:0]  src_x, src_y;
    logic [SUB_W-1:0]            sub_w, sub_h;
    logic [ssfs_pkg::CELL_W-1:0] rem_w, rem_h;
    logic [ssfs_pkg::SIZE_W-1:0] src_w, src_h;
    logic [ssfs_pkg::FRAME_W-1:0] frame_now;

    assign pad_l = cfg.padding_packed[7:0];
    assign pad_r = cfg.padding_packed[15:8];
    assign pad_t = cfg.padding_packed[23:16];
    assign pad_b = cfg.padding_packed[31:24];

    // Time step: reload on zero or below, drop the leftover
    assign cd_dec    = countdown_reg - ssfs_pkg::CD_W'(s_elapsed);
    assign frame_inc = {1'b0, frame_reg} + (FRAME_BITS + 1)'(1);
    always_comb begin
        if (CMP_W'(frame_inc) > CMP_W'(cfg.last_frame)) begin
            frame_adv = cfg.loop_enable ? FRAME_BITS'(cfg.first_frame)
                                        : FRAME_BITS'(cfg.last_frame);
        end else begin
            frame_adv = frame_inc[FRAME_BITS-1:0];
        end
    end

    // Frame zero maps to the first cell
    assign frame_idx = (frame_reg == '0) ? '0 : frame_reg - FRAME_BITS'(1);
    assign cols      = (cfg.num_columns == '0) ? ssfs_pkg::COLS_W'(1) : cfg.num_columns;

    // One quotient bit per cycle, restoring
    assign trial = {rem_reg, quot_reg[FRAME_BITS-1]};
    assign ge    = trial >= {1'b0, cols};
    assign diff  = trial - {1'b0, cols};

    assign sum_x = (PX_W + 1)'(prod_x_reg) + (PX_W + 1)'({pad_l, 8'h00});
    assign sum_y = (PY_W + 1)'(prod_y_reg) + (PY_W + 1)'({pad_t, 8'h00});
    assign pix_x = sum_x[PX_W:ssfs_pkg::FRAC_W];
    assign pix_y = sum_y[PY_W:ssfs_pkg::FRAC_W];
    assign src_x = (|pix_x[XP_W-1:ssfs_pkg::POS_W]) ? '1 : pix_x[ssfs_pkg::POS_W-1:0];
    assign src_y = (|pix_y[YP_W-1:ssfs_pkg::POS_W]) ? '1 : pix_y[ssfs_pkg::POS_W-1:0];

    assign sub_w = {(9'(pad_l) + 9'(pad_r)), 8'h00};
    assign sub_h = {(9'(pad_t) + 9'(pad_b)), 8'h00};
    assign rem_w = cfg.cell_width_q8 - ssfs_pkg::CELL_W'(sub_w);
    assign rem_h = cfg.cell_height_q8 - ssfs_pkg::CELL_W'(sub_h);
    assign src_w = (ssfs_pkg::CELL_W'(sub_w) >= cfg.cell_width_q8) ? '0
                   : rem_w[ssfs_pkg::CELL_W-1:ssfs_pkg::FRAC_W];
    assign src_h = (ssfs_pkg::CELL_W'(sub_h) >= cfg.cell_height_q8) ? '0
                   : rem_h[ssfs_pkg::CELL_W-1:ssfs_pkg::FRAC_W];
    assign frame_now = ssfs_pkg::FRAME_W'(frame_reg);

    always_comb begin
        countdown_next = countdown_reg;
        frame_next     = frame_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        prod_x_next    = prod_x_reg;
        prod_y_next    = prod_y_reg;
        tdata_next     = tdata_reg;
        tvalid_next    = tvalid_reg && !m_tready;

        if (cmd.step) begin
            if (s_op == ssfs_pkg::OP_RESTART) begin
                frame_next     = FRAME_BITS'(cfg.first_frame);
                countdown_next = ssfs_pkg::CD_W'(cfg.frame_period);
            end else if (cd_dec[ssfs_pkg::CD_W-1] || cd_dec == '0) begin
                frame_next     = frame_adv;
                countdown_next = ssfs_pkg::CD_W'(cfg.frame_period);
            end else begin
                countdown_next = cd_dec;
            end
        end
        if (cmd.div_start) begin
            quot_next = frame_idx;
            rem_next  = '0;
            cnt_next  = '0;
        end
        if (cmd.div_step) begin
            quot_next = {quot_reg[FRAME_BITS-2:0], ge};
            rem_next  = ge ? diff[ssfs_pkg::COLS_W-1:0] : trial[ssfs_pkg::COLS_W-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        if (cmd.mul) begin
            prod_x_next = PX_W'(rem_reg) * PX_W'(cfg.cell_width_q8);
            prod_y_next = PY_W'(quot_reg) * PY_W'(cfg.cell_height_q8);
        end
        if (cmd.load_out) begin
            tdata_next  = {6'b0, frame_now, src_h, src_w, src_y, src_x};
            tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= '0;
            frame_reg     <= FRAME_BITS'(1);
            cnt_reg       <= '0;
            tvalid_reg    <= 1'b0;
        end else begin
            countdown_reg <= countdown_next;
            frame_reg     <= frame_next;
            cnt_reg       <= cnt_next;
            tvalid_reg    <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        tdata_reg  <= tdata_next;
    end

    assign sts.div_last = cnt_reg == CNT_W'(FRAME_BITS - 1);
    assign sts.out_free = !tvalid_reg || m_tready;
    assign m_tvalid     = tvalid_reg;
    assign m_tdata      = tdata_reg;

endmodule
